/* src/dlip_pkg.sv */
`timescale 1ns / 1ps
package dlip_pkg;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_PERIOD  = 8'd46;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_INT = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_BOUNDS  = 2'd3;

    // Register indexes
    localparam logic REG_BOUND_A = 1'b0;
    localparam logic REG_BOUND_B = 1'b1;

    localparam logic [31:0] MAG_LIMIT   = 32'h8000_0000;
    localparam logic [31:0] BOUND_A_RST = 32'h8000_0000;
    localparam logic [31:0] BOUND_B_RST = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] number;
    } t_result;

endpackage

/* src/dlip_parse.sv */
`timescale 1ns / 1ps
module dlip_parse
    import dlip_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_char,
    input  logic signed [31:0] i_lo,
    input  logic signed [31:0] i_hi,
    output t_result            o_res
);

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_MINUS  = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_TAIL   = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [31:0] r_mag, n_mag;
    logic        r_too_big, n_too_big;
    logic        r_reject, n_reject;

    logic               is_digit;
    logic [35:0]        mag_next;
    logic               mag_ovf;
    logic [31:0]        mag_digit;
    logic               pending;
    logic signed [31:0] value;

    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    // times ten as shift and add
    assign mag_next  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                     + {32'd0, i_char[3:0]};
    assign mag_ovf   = r_too_big || (mag_next > {4'd0, MAG_LIMIT});
    assign mag_digit = mag_ovf ? MAG_LIMIT : mag_next[31:0];

    always_comb begin
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_mag     = r_mag;
        n_too_big = r_too_big;
        n_reject  = r_reject;
        if (i_char == CH_NEWLINE) begin
            n_phase   = PH_SKIP;
            n_neg     = 1'b0;
            n_mag     = '0;
            n_too_big = 1'b0;
            n_reject  = 1'b0;
        end else begin
            unique case (r_phase)
                PH_SKIP: begin
                    if (i_char == CH_SPACE || i_char == CH_TAB) begin
                        n_phase = PH_SKIP;
                    end else if (i_char == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_MINUS;
                    end else if (is_digit) begin
                        n_mag     = mag_digit;
                        n_too_big = mag_ovf;
                        n_phase   = PH_DIGITS;
                    end else begin
                        n_reject = 1'b1;
                        n_phase  = PH_TAIL;
                    end
                end
                PH_MINUS: begin
                    if (is_digit) begin
                        n_mag     = mag_digit;
                        n_too_big = mag_ovf;
                        n_phase   = PH_DIGITS;
                    end else begin
                        n_reject = 1'b1;
                        n_phase  = PH_TAIL;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        n_mag     = mag_digit;
                        n_too_big = mag_ovf;
                    end else begin
                        n_reject = (i_char == CH_PERIOD);
                        n_phase  = PH_TAIL;
                    end
                end
                default: begin
                    n_phase = PH_TAIL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SKIP;
            r_neg     <= 1'b0;
            r_mag     <= '0;
            r_too_big <= 1'b0;
            r_reject  <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_mag     <= n_mag;
            r_too_big <= n_too_big;
            r_reject  <= n_reject;
        end
    end

    // Verdict for a line ending now
    assign pending = (r_phase == PH_DIGITS) || (r_phase == PH_TAIL && !r_reject);
    assign value   = r_neg ? $signed(-r_mag) : $signed(r_mag);

    always_comb begin
        o_res.status = ST_NOT_INT;
        o_res.number = '0;
        if (pending) begin
            if (r_too_big || (!r_neg && r_mag[31])) begin
                o_res.status = ST_RANGE;
            end else if (value >= i_lo && value <= i_hi) begin
                o_res.status = ST_OK;
                o_res.number = value;
            end else begin
                o_res.status = ST_BOUNDS;
            end
        end
    end

endmodule

/* src/decimal_line_int_parser.sv */
`timescale 1ns / 1ps
// A newline passes through the input register and then the result register before its result shows on the master side.
// Throughput: one character per cycle, except that a newline waits while the result slot is full; the
// magnitude update (shift-add times ten, add digit, compare to 2^31) is the combinational path that sets this rate.
// Reset: synchronous, active low; clears the line state, both stage valids, and loads the
// bounds with -2^31 and 2^31-1.
module decimal_line_int_parser
    import dlip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    // line results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] number
    output logic [1:0]  m_tuser,   // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Bound registers as written, plus an ordered copy (low, high)
    logic signed [31:0] r_bound_a;
    logic signed [31:0] r_bound_b;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;

    // Input register stage
    logic       r_in_valid;
    logic [7:0] r_char;

    // Result register stage
    logic    r_out_valid;
    t_result r_out;

    logic    cfg_wr;
    logic    is_nl;
    logic    out_free;
    logic    step;
    t_result line_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register index is the word address; low byte bits do not decode
    always_comb begin
        unique case (paddr[2])
            REG_BOUND_A: prdata = r_bound_a;
            REG_BOUND_B: prdata = r_bound_b;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_a <= BOUND_A_RST;
            r_bound_b <= BOUND_B_RST;
            r_lo      <= BOUND_A_RST;
            r_hi      <= BOUND_B_RST;
        end else begin
            if (cfg_wr && paddr[2] == REG_BOUND_A) begin
                r_bound_a <= pwdata;
            end
            if (cfg_wr && paddr[2] == REG_BOUND_B) begin
                r_bound_b <= pwdata;
            end
            // Swap when the bounds come in reverse order; the ordered copy is registered from the written bounds
            // and settles before any character taken afterward reaches the parser
            if (r_bound_a > r_bound_b) begin
                r_lo <= r_bound_b;
                r_hi <= r_bound_a;
            end else begin
                r_lo <= r_bound_a;
                r_hi <= r_bound_b;
            end
        end
    end

    // A newline needs the result slot; other characters always advance
    assign is_nl    = (r_char == CH_NEWLINE);
    assign out_free = !r_out_valid || m_tready;
    assign step     = r_in_valid && (!is_nl || out_free);
    assign s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_char <= s_tdata;
        end
    end

    dlip_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_res   (line_res)
    );

    // Load the result slot on a newline, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && is_nl) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && is_nl) begin
            r_out <= line_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out.number;
    assign m_tuser  = r_out.status;

`ifndef NO_ASSERTIONS
    a_number_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("nonzero number on a rejected line");

    a_ok_within_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && is_nl && line_res.status == ST_OK)
            |-> (line_res.number >= r_lo && line_res.number <= r_hi))
        else $error("accepted number outside bounds");

    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("ordered bounds out of order");

    a_newline_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && is_nl && r_out_valid && !m_tready)
            |=> (r_in_valid && is_nl && r_out_valid))
        else $error("newline lost while result slot full");
`endif

endmodule
